FILE: rtl/core/sdf_pkg.sv
// shared types and constants for the signed decimal formatter
package sdf_pkg;

    localparam int MAX_RESULTS = 14;
    localparam int CNT_W       = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT,
        ST_SEP
    } sdf_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } dab_ctrl_t;

endpackage

FILE: rtl/core/signed_decimal_formatter.sv
// signed integer to decimal ascii text with optional digit grouping
// steps: accept in idle, VALUE_BITS shift-add-3 steps in the bcd unit, then
//   leading zeros are skipped before the first character
// throughput: one character per cycle while out_ready is high; a new value is
//   accepted only in idle, after the last character of the previous one
// reset clears the sequencer, output valid and group_separator (grouping off)
module signed_decimal_formatter #(
    parameter int VALUE_BITS   = 32,
    parameter int GROUP_DIGITS = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          group_separator_we,
    input  logic [7:0]                    group_separator,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [VALUE_BITS-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    char_code,
    output logic                          last_char
);

    localparam int DIGITS  = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
    localparam int IDX_W   = $clog2(DIGITS);
    localparam int GRP_W   = $clog2(GROUP_DIGITS);
    localparam int STEP_W  = $clog2(VALUE_BITS);
    localparam int TOP_GRP = (DIGITS - 1) % GROUP_DIGITS;

    sdf_pkg::sdf_state_t state_reg, state_next;

    logic [7:0]                sep_reg;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [GRP_W-1:0]          grp_reg, grp_next, grp_dec;
    logic [sdf_pkg::CNT_W-1:0] emit_reg, emit_next;
    logic                      neg_reg, neg_next;
    logic                      out_valid_reg, out_valid_next;
    logic [7:0]                char_reg, char_next;
    logic                      last_reg, last_next;

    sdf_pkg::dab_ctrl_t  dab_ctrl;
    logic [DIGITS*4-1:0] bcd;
    logic [3:0]          digit_sel;
    logic                out_free;
    logic                at_cap;

    sdf_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_dabble (
        .clk   (clk),
        .ctrl  (dab_ctrl),
        .value (value),
        .bcd   (bcd)
    );

    assign digit_sel = bcd[idx_reg*4 +: 4];
    assign out_free  = !out_valid_reg || out_ready;
    assign at_cap    = (emit_reg == sdf_pkg::CNT_W'(sdf_pkg::MAX_RESULTS - 1));
    assign grp_dec   = (grp_reg == '0) ? GRP_W'(GROUP_DIGITS - 1) : grp_reg - 1'b1;
    assign in_ready  = (state_reg == sdf_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        grp_next       = grp_reg;
        emit_next      = emit_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        dab_ctrl.load  = 1'b0;
        dab_ctrl.step  = 1'b0;

        unique case (state_reg)
            sdf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    dab_ctrl.load = 1'b1;
                    neg_next      = value[VALUE_BITS-1];
                    step_next     = '0;
                    emit_next     = '0;
                    state_next    = sdf_pkg::ST_CONVERT;
                end
            end
            sdf_pkg::ST_CONVERT:
            begin
                dab_ctrl.step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(VALUE_BITS - 1))
                begin
                    idx_next   = IDX_W'(DIGITS - 1);
                    grp_next   = GRP_W'(TOP_GRP);
                    state_next = sdf_pkg::ST_SKIP;
                end
            end
            sdf_pkg::ST_SKIP:
            begin
                // drop leading zeros, keep the units digit
                if (digit_sel == 4'd0 && idx_reg != '0)
                begin
                    idx_next = idx_reg - 1'b1;
                    grp_next = grp_dec;
                end
                else if (neg_reg)
                begin
                    state_next = sdf_pkg::ST_SIGN;
                end
                else
                begin
                    state_next = sdf_pkg::ST_DIGIT;
                end
            end
            sdf_pkg::ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = sdf_pkg::CHAR_MINUS;
                    last_next      = at_cap;
                    emit_next      = emit_reg + 1'b1;
                    state_next     = at_cap ? sdf_pkg::ST_IDLE : sdf_pkg::ST_DIGIT;
                end
            end
            sdf_pkg::ST_DIGIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = sdf_pkg::CHAR_ZERO + {4'd0, digit_sel};
                    last_next      = at_cap || (idx_reg == '0);
                    emit_next      = emit_reg + 1'b1;
                    if (at_cap || idx_reg == '0)
                    begin
                        state_next = sdf_pkg::ST_IDLE;
                    end
                    else if (grp_reg == '0 && sep_reg != 8'd0)
                    begin
                        state_next = sdf_pkg::ST_SEP;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                        grp_next = grp_dec;
                    end
                end
            end
            sdf_pkg::ST_SEP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = sep_reg;
                    last_next      = at_cap;
                    emit_next      = emit_reg + 1'b1;
                    idx_next       = idx_reg - 1'b1;
                    grp_next       = grp_dec;
                    state_next     = at_cap ? sdf_pkg::ST_IDLE : sdf_pkg::ST_DIGIT;
                end
            end
            default:
            begin
                state_next = sdf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdf_pkg::ST_IDLE;
            sep_reg       <= 8'd0;
            step_reg      <= '0;
            idx_reg       <= '0;
            grp_reg       <= '0;
            emit_reg      <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            grp_reg       <= grp_next;
            emit_reg      <= emit_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
            if (group_separator_we)
            begin
                sep_reg <= group_separator;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

    a_convert_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdf_pkg::ST_CONVERT && step_reg == STEP_W'(VALUE_BITS - 1))
        |=> state_reg == sdf_pkg::ST_SKIP)
        else $error("bcd conversion did not end after VALUE_BITS steps");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == sdf_pkg::ST_CONVERT)
        else $error("accepted beat did not start conversion");

    a_emit_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdf_pkg::ST_SIGN || state_reg == sdf_pkg::ST_DIGIT
            || state_reg == sdf_pkg::ST_SEP)
        |-> emit_reg < sdf_pkg::CNT_W'(sdf_pkg::MAX_RESULTS))
        else $error("character count ran past the limit");

    a_sep_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdf_pkg::ST_SEP) |-> (sep_reg != 8'd0 && idx_reg != '0))
        else $error("separator emitted with grouping off or after units digit");

endmodule

FILE: rtl/core/sdf_dabble.sv
// shift-add-3 binary to bcd unit, one bit per step
module sdf_dabble #(
    parameter int VALUE_BITS = 32,
    parameter int DIGITS     = 10
) (
    input  logic                          clk,
    input  sdf_pkg::dab_ctrl_t            ctrl,
    input  logic signed [VALUE_BITS-1:0]  value,
    output logic [DIGITS*4-1:0]           bcd
);

    logic [VALUE_BITS-1:0] bin_reg;
    logic [VALUE_BITS-1:0] bin_next;
    logic [DIGITS*4-1:0]   bcd_reg;
    logic [DIGITS*4-1:0]   bcd_next;
    logic [DIGITS*4-1:0]   bcd_adj;
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;

    // most negative value wraps to its own pattern, read as unsigned
    assign raw = $unsigned(value);
    assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] >= 4'd5)
            begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctrl.load)
        begin
            bin_next = mag;
            bcd_next = '0;
        end
        else if (ctrl.step)
        begin
            bcd_next = {bcd_adj[DIGITS*4-2:0], bin_reg[VALUE_BITS-1]};
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign bcd = bcd_reg;

endmodule
